@@ rtl/lppc_pkg.sv @@
`timescale 1ns / 1ps

package lppc_pkg;

  localparam logic [15:0] CRC_POLY      = 16'h8005;
  localparam logic [15:0] MAX_LEN_RESET = 16'd4096;
  localparam int          HEAD_END      = 7;
  localparam int          POS_W         = 17;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [1:0] STATUS_BAD_CRC  = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       start_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  source_node;
    logic [7:0]  dest_node;
    logic [7:0]  send_sequence;
    logic [7:0]  ack_sequence;
    logic [7:0]  packet_kind;
    logic [15:0] payload_length;
    logic [15:0] received_check;
    logic [15:0] computed_check;
  } out_item_t;

  // byte-wide crc update, msb first, no reflection
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/length_prefixed_packet_checker_top.sv @@
`timescale 1ns / 1ps

// Length-prefixed packet checker.
// in channel: one received byte per item, start_of_packet marks the first
// byte of a packet and restarts parsing from any state. Packet layout:
// 16-bit big-endian payload length, source, destination, send sequence,
// ack sequence, type, payload, 16-bit big-endian CRC-16 (poly 0x8005,
// init 0) over every byte before the trailer.
// out channel: at most one item per packet, after the last trailer byte, or right
// after the second byte when the length exceeds max_payload_length.
// cfg_wr_en / cfg_wr_data write max_payload_length (reset value 4096).
// Throughput is one byte per cycle while in_stall is low: the byte-wide
// crc update and the position compare sit between the parser state
// registers. The output register raises out_valid in the cycle after the
// accepted byte. in_stall rises only while a result is held in the output
// register and the receiver stalls it. Synchronous reset clears the parser
// to idle and empties the output register.
module length_prefixed_packet_checker_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lppc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lppc_pkg::out_item_t out_item,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data
);

  logic [15:0]                  max_payload_length;
  logic [lppc_pkg::POS_W-1:0]   byte_position, byte_position_next;
  logic                         parsing_active, parsing_active_next;
  logic [15:0]                  length_register, length_register_next;
  logic [15:0]                  crc_register, crc_register_next;
  logic [7:0]                   header_bytes [5];
  logic [7:0]                   header_bytes_next [5];
  logic [15:0]                  trailer_register, trailer_register_next;

  logic                         in_accept;
  logic                         emit;
  lppc_pkg::out_item_t          result;

  logic [lppc_pkg::POS_W-1:0]   p;
  logic [lppc_pkg::POS_W-1:0]   limit;
  logic [15:0]                  len_base, crc_base, trl_base, full_len, full_trl;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    byte_position_next    = byte_position;
    parsing_active_next   = parsing_active;
    length_register_next  = length_register;
    crc_register_next     = crc_register;
    trailer_register_next = trailer_register;
    header_bytes_next     = header_bytes;
    emit                  = 1'b0;
    result                = '0;

    // start byte clears the packet context before it is parsed
    if (in_item.start_of_packet) begin
      p        = '0;
      len_base = '0;
      crc_base = '0;
      trl_base = '0;
      for (int j = 0; j < 5; j++) begin
        header_bytes_next[j] = '0;
      end
    end else begin
      p        = byte_position;
      len_base = length_register;
      crc_base = crc_register;
      trl_base = trailer_register;
    end

    limit    = {1'b0, len_base} + lppc_pkg::POS_W'(lppc_pkg::HEAD_END);
    full_len = {len_base[15:8], in_item.rx_byte};
    full_trl = {trl_base[15:8], in_item.rx_byte};

    if (in_item.start_of_packet || parsing_active) begin
      parsing_active_next  = 1'b1;
      byte_position_next   = p + lppc_pkg::POS_W'(1);
      length_register_next = len_base;
      crc_register_next    = crc_base;
      trailer_register_next = trl_base;

      if (p < limit) begin
        crc_register_next = lppc_pkg::crc_feed(crc_base, in_item.rx_byte);
        if (p == '0) begin
          length_register_next = {in_item.rx_byte, 8'h00};
        end else if (p == lppc_pkg::POS_W'(1)) begin
          length_register_next = full_len;
          if (full_len > max_payload_length) begin
            parsing_active_next   = 1'b0;
            emit                  = 1'b1;
            result.status         = lppc_pkg::STATUS_TOO_LONG;
            result.payload_length = full_len;
          end
        end else if (p < lppc_pkg::POS_W'(lppc_pkg::HEAD_END)) begin
          header_bytes_next[p[2:0] - 3'd2] = in_item.rx_byte;
        end
      end else if (p == limit) begin
        trailer_register_next = {in_item.rx_byte, 8'h00};
      end else begin
        trailer_register_next = full_trl;
        parsing_active_next   = 1'b0;
        emit                  = 1'b1;
        result.status         = (full_trl == crc_base) ? lppc_pkg::STATUS_OK
                                                       : lppc_pkg::STATUS_BAD_CRC;
        result.source_node    = header_bytes_next[0];
        result.dest_node      = header_bytes_next[1];
        result.send_sequence  = header_bytes_next[2];
        result.ack_sequence   = header_bytes_next[3];
        result.packet_kind    = header_bytes_next[4];
        result.payload_length = len_base;
        result.received_check = full_trl;
        result.computed_check = crc_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_length <= lppc_pkg::MAX_LEN_RESET;
      byte_position      <= '0;
      parsing_active     <= 1'b0;
      length_register    <= '0;
      crc_register       <= '0;
      trailer_register   <= '0;
      for (int j = 0; j < 5; j++) begin
        header_bytes[j] <= '0;
      end
      out_valid          <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_payload_length <= cfg_wr_data;
      end
      if (in_accept) begin
        byte_position    <= byte_position_next;
        parsing_active   <= parsing_active_next;
        length_register  <= length_register_next;
        crc_register     <= crc_register_next;
        trailer_register <= trailer_register_next;
        header_bytes     <= header_bytes_next;
      end
      if (in_accept && emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_item <= result;
    end
  end

endmodule

@@ dv/lppc_frame_checker.sv @@
`timescale 1ns / 1ps

module lppc_frame_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  lppc_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  lppc_pkg::out_item_t out_item,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  output int unsigned         fail_count,
  output int unsigned         reports_checked,
  output int unsigned         outstanding
);

  import lppc_pkg::*;

  // parser copy, advanced on every accepted item
  logic [16:0] frame_pos;
  logic        frame_open;
  logic [15:0] frame_len;
  logic [15:0] running_crc;
  logic [15:0] trailer_crc;
  logic [15:0] len_limit;
  logic [7:0]  header [5];

  out_item_t pending_reports [$];

  // bitwise msb-first crc, one data bit per iteration
  function automatic logic [15:0] crc16_bitwise(input logic [15:0] acc, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ d[i];
      acc = {acc[14:0], 1'b0};
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  task automatic absorb_byte(input in_item_t it);
    int        p;
    int        body_end;
    out_item_t r;
    if (it.start_of_packet) begin
      frame_pos   = '0;
      frame_open  = 1'b1;
      frame_len   = '0;
      running_crc = '0;
      trailer_crc = '0;
      foreach (header[k]) header[k] = '0;
    end else if (!frame_open) begin
      return;
    end
    p         = frame_pos;
    frame_pos = frame_pos + 17'd1;
    body_end  = HEAD_END + int'(frame_len);
    r         = '0;
    if (p < body_end) begin
      running_crc = crc16_bitwise(running_crc, it.rx_byte);
      if (p == 0) begin
        frame_len = {it.rx_byte, 8'h00};
      end else if (p == 1) begin
        frame_len = {frame_len[15:8], it.rx_byte};
        // length checked against the limit in force right now
        if (frame_len > len_limit) begin
          frame_open       = 1'b0;
          r.status         = STATUS_TOO_LONG;
          r.payload_length = frame_len;
          pending_reports.push_back(r);
        end
      end else if (p < HEAD_END) begin
        header[p - 2] = it.rx_byte;
      end
    end else if (p == body_end) begin
      trailer_crc = {it.rx_byte, 8'h00};
    end else begin
      trailer_crc      = {trailer_crc[15:8], it.rx_byte};
      frame_open       = 1'b0;
      r.status         = (trailer_crc == running_crc) ? STATUS_OK : STATUS_BAD_CRC;
      r.source_node    = header[0];
      r.dest_node      = header[1];
      r.send_sequence  = header[2];
      r.ack_sequence   = header[3];
      r.packet_kind    = header[4];
      r.payload_length = frame_len;
      r.received_check = trailer_crc;
      r.computed_check = running_crc;
      pending_reports.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("report %0d %s: expected %h got %h", reports_checked, name, want, got);
      end
    end
  endtask

  task automatic check_report(input out_item_t got);
    out_item_t want;
    if (pending_reports.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("unexpected report: %p", got);
      end
      return;
    end
    want = pending_reports.pop_front();
    check_field("status", 16'(want.status), 16'(got.status));
    check_field("source_node", 16'(want.source_node), 16'(got.source_node));
    check_field("dest_node", 16'(want.dest_node), 16'(got.dest_node));
    check_field("send_sequence", 16'(want.send_sequence), 16'(got.send_sequence));
    check_field("ack_sequence", 16'(want.ack_sequence), 16'(got.ack_sequence));
    check_field("packet_kind", 16'(want.packet_kind), 16'(got.packet_kind));
    check_field("payload_length", want.payload_length, got.payload_length);
    check_field("received_check", want.received_check, got.received_check);
    check_field("computed_check", want.computed_check, got.computed_check);
    reports_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_pos       = '0;
      frame_open      = 1'b0;
      frame_len       = '0;
      running_crc     = '0;
      trailer_crc     = '0;
      len_limit       = MAX_LEN_RESET;
      foreach (header[k]) header[k] = '0;
      pending_reports.delete();
      fail_count      = 0;
      reports_checked = 0;
    end else begin
      // a report leaves in the cycle after its item at the earliest
      if (out_valid && !out_stall) begin
        check_report(out_item);
      end
      if (cfg_wr_en) begin
        len_limit = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        absorb_byte(in_item);
      end
    end
    outstanding = pending_reports.size();
  end

endmodule

@@ dv/length_prefixed_packet_checker_top_tb.sv @@
`timescale 1ns / 1ps

module length_prefixed_packet_checker_top_tb;

  import lppc_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  int unsigned fail_count;
  int unsigned reports_checked;
  int unsigned outstanding;

  bit          no_gaps;
  logic [15:0] cur_limit;
  int unsigned bytes_sent;
  int unsigned packets_sent;

  length_prefixed_packet_checker_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  lppc_frame_checker u_frame_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .fail_count      (fail_count),
    .reports_checked (reports_checked),
    .outstanding     (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !no_gaps && ($urandom_range(99) < 14);
    end
  end

  initial begin
    #12_000_000;
    $display("length_prefixed_packet_checker_top test failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic sop);
    in_item.rx_byte         <= b;
    in_item.start_of_packet <= sop;
    in_valid                <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (!no_gaps && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // cut < 0 sends the whole packet, otherwise only the first cut bytes
  task automatic send_packet(input logic [15:0] len, input logic [39:0] hdr,
                             input int cut, input bit bad_crc);
    int          plen;
    int          total;
    logic [15:0] crc;
    logic [15:0] trailer;
    logic [7:0]  b;
    plen    = len;
    total   = plen + 9;
    crc     = '0;
    trailer = '0;
    packets_sent++;
    for (int i = 0; i < total; i++) begin
      if (cut >= 0 && i >= cut) break;
      if (i == 0) begin
        b = len[15:8];
      end else if (i == 1) begin
        b = len[7:0];
      end else if (i < HEAD_END) begin
        b = hdr[8 * (6 - i) +: 8];
      end else if (i < HEAD_END + plen) begin
        b = 8'($urandom());
      end else if (i == HEAD_END + plen) begin
        trailer = bad_crc ? (crc ^ (16'h0001 << $urandom_range(15))) : crc;
        b       = trailer[15:8];
      end else begin
        b = trailer[7:0];
      end
      if (i < HEAD_END + plen) begin
        crc = crc_feed(crc, b);
      end
      send_byte(b, i == 0);
    end
  endtask

  task automatic wait_reports_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_len_limit(input logic [15:0] v);
    wait_reports_drained();
    // a byte that makes no report may still be in flight
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_limit    = v;
  endtask

  task automatic run_traffic(input int unsigned budget);
    int unsigned used;
    int unsigned pick;
    int unsigned hi;
    int unsigned len;
    int unsigned cut;
    used = 0;
    while (used < budget) begin
      pick = $urandom_range(99);
      hi   = ($urandom_range(9) == 0) ? 60 : 16;
      if (hi > cur_limit) hi = cur_limit;
      if (pick < 64) begin
        len = $urandom_range(0, hi);
        send_packet(16'(len), {$urandom(), 8'($urandom())}, -1, $urandom_range(9) == 0);
        used += len + 9;
      end else if (pick < 76 && cur_limit != 16'hFFFF) begin
        // rejected length, trailing bytes are dropped by the block
        len = $urandom_range(int'(cur_limit) + 1, 65535);
        send_packet(16'(len), {$urandom(), 8'($urandom())}, 2 + $urandom_range(0, 5), 0);
        used += 2;
      end else if (pick < 90) begin
        // broken off mid-packet, the next start restarts parsing
        len = $urandom_range(0, hi);
        cut = $urandom_range(1, len + 8);
        send_packet(16'(len), {$urandom(), 8'($urandom())}, cut, 0);
        used += cut;
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom()), 1'b0);
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_item      = '0;
    out_stall    = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    no_gaps      = 1'b0;
    cur_limit    = MAX_LEN_RESET;
    bytes_sent   = 0;
    packets_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, under the reset limit
    send_packet(16'd0, 40'hFF_FF_FF_FF_FF, -1, 0);
    send_byte(8'hA5, 1'b0);
    send_packet(16'd4097, 40'h0, 3, 0);
    send_packet(16'hFFFF, 40'h0, 2, 0);
    send_packet(16'd3, 40'h01_02_03_04_05, 4, 0);
    send_packet(16'd1, 40'h00_00_00_00_00, -1, 1);

    write_len_limit(16'd20);
    run_traffic(150);

    write_len_limit(16'hFFFF);
    run_traffic(150);

    write_len_limit(16'd0);
    run_traffic(150);

    write_len_limit(16'($urandom_range(1, 40)));
    no_gaps <= 1'b1;
    run_traffic(150);
    wait_reports_drained();
    no_gaps <= 1'b0;

    write_len_limit(MAX_LEN_RESET);
    run_traffic(150);

    wait_reports_drained();
    repeat (10) @(posedge clk);
    $display("drove %0d bytes in %0d packets over five length limits incl. 0 and 65535",
             bytes_sent, packets_sent);
    $display("checked %0d reports, %0d field mismatches", reports_checked, fail_count);
    if (fail_count == 0) begin
      $display("length_prefixed_packet_checker_top test passed");
    end else begin
      $display("length_prefixed_packet_checker_top test failed");
    end
    $finish;
  end

endmodule
